@@ rtl/palette_bayer_dither_framebuffer_assert.svh @@
//------------------------------------------------------------------------------
// Assertion macros for the palette dither framebuffer
// Shared property templates used by the port checker.
//------------------------------------------------------------------------------
`ifndef PALETTE_BAYER_DITHER_FRAMEBUFFER_ASSERT_SVH
`define PALETTE_BAYER_DITHER_FRAMEBUFFER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBD_ASSERT_SAME(name, clock, reset_n, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error("palette dither framebuffer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PBD_ASSERT_NEXT(name, clock, reset_n, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error("palette dither framebuffer check failed");

`endif

@@ rtl/pbd_pkg.sv @@
//------------------------------------------------------------------------------
// pbd_pkg
// Shared codes, the Bayer threshold table and the per-transaction control word.
//------------------------------------------------------------------------------
`default_nettype none

package pbd_pkg;

    // Transaction kinds carried on the action field.
    localparam logic [1:0] ACT_PALETTE_WRITE = 2'd0;
    localparam logic [1:0] ACT_DRAW_PIXEL    = 2'd1;
    localparam logic [1:0] ACT_FB_READ       = 2'd2;
    localparam logic [1:0] ACT_FB_WRITE      = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_CLIPPED = 2'd1;
    localparam logic [1:0] STATUS_SKIPPED = 2'd2;
    localparam logic [1:0] STATUS_DRAWN   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_OFFSET_X           = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y           = 2'd1;
    localparam logic [1:0] REG_TRANSPARENT_ENABLE = 2'd2;
    localparam logic [1:0] REG_TRANSPARENT_INDEX  = 2'd3;

    localparam int CFG_DATA_W = 12;

    // 8x8 ordered dither thresholds, indexed [row][column].
    localparam logic [5:0] BAYER_TAB [8][8] = '{
        '{6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42},
        '{6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26},
        '{6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38},
        '{6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22},
        '{6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41},
        '{6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25},
        '{6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37},
        '{6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21}
    };

    function automatic logic [5:0] bayer_threshold(input logic [2:0] row,
                                                   input logic [2:0] col);
        return BAYER_TAB[row][col];
    endfunction

    // Control word decoded at acceptance and carried to the write-back stage.
    typedef struct packed {
        logic [1:0] status;   // final status code
        logic       fb_wr;    // framebuffer byte is written back
        logic       store;    // byte comes from the transaction, not from dithering
        logic       rd_ok;    // framebuffer read in range
        logic       pal_oob;  // palette index beyond the palette, colour is zero
        logic [7:0] mask;     // pixel bit within the byte
        logic [5:0] thresh;   // dither threshold at the pixel position
        logic [7:0] wr_byte;  // byte for a framebuffer write
    } pbd_op_t;

endpackage

`default_nettype wire

@@ rtl/pbd_ram.sv @@
//------------------------------------------------------------------------------
// pbd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
//------------------------------------------------------------------------------
`default_nettype none

module pbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/pbd_decode.sv @@
//------------------------------------------------------------------------------
// pbd_decode
// Acceptance-stage decode: clipping, transparency, byte address and threshold.
//------------------------------------------------------------------------------
`default_nettype none

module pbd_decode #(
    parameter int FB_WIDTH     = 296,
    parameter int FB_HEIGHT    = 128,
    parameter int PALETTE_SIZE = 256,
    localparam int ROW_BYTES   = (FB_WIDTH + 7) / 8,
    localparam int FB_BYTES    = ROW_BYTES * FB_HEIGHT,
    localparam int FB_AW       = $clog2(FB_BYTES)
) (
    input  wire logic [1:0]       action,
    input  wire logic [10:0]      pix_x,
    input  wire logic [10:0]      pix_y,
    input  wire logic [7:0]       color_index,
    input  wire logic [12:0]      fb_address,
    input  wire logic [7:0]       fb_byte,
    input  wire logic [11:0]      offset_x,
    input  wire logic [11:0]      offset_y,
    input  wire logic             transparent_enable,
    input  wire logic [7:0]       transparent_index,
    output      pbd_pkg::pbd_op_t op,
    output      logic [FB_AW-1:0] fb_addr,
    output      logic             pal_hit
);

    logic [12:0]      x_off;
    logic [12:0]      y_off;
    logic             row_out;
    logic             col_out;
    logic             transp;
    logic             addr_in_range;
    logic [FB_AW-1:0] pix_addr;

    // Signed offset plus unsigned canvas position; bit 12 is the sign.
    assign x_off = {offset_x[11], offset_x} + {2'b00, pix_x};
    assign y_off = {offset_y[11], offset_y} + {2'b00, pix_y};

    assign row_out = y_off[12] || (32'(y_off[11:0]) >= FB_HEIGHT);
    assign col_out = x_off[12] || (32'(x_off[11:0]) >= FB_WIDTH);
    assign transp  = transparent_enable && (color_index == transparent_index);

    assign pix_addr      = FB_AW'(32'(y_off[11:0]) * ROW_BYTES + 32'(x_off[11:3]));
    assign addr_in_range = 32'(fb_address) < FB_BYTES;
    assign pal_hit       = 32'(color_index) < PALETTE_SIZE;

    always_comb
    begin
        op         = '0;
        op.status  = pbd_pkg::STATUS_DONE;
        op.mask    = 8'h80 >> x_off[2:0];
        op.thresh  = pbd_pkg::bayer_threshold(y_off[2:0], x_off[2:0]);
        op.wr_byte = fb_byte;
        op.pal_oob = !pal_hit;
        fb_addr    = FB_AW'(fb_address);
        unique case (action)
            pbd_pkg::ACT_PALETTE_WRITE:
            begin
                op.status = pbd_pkg::STATUS_DONE;
            end
            pbd_pkg::ACT_DRAW_PIXEL:
            begin
                fb_addr = pix_addr;
                // Row clipping wins over transparency; transparency wins over
                // column clipping.
                if (row_out)
                begin
                    op.status = pbd_pkg::STATUS_CLIPPED;
                end
                else if (transp)
                begin
                    op.status = pbd_pkg::STATUS_SKIPPED;
                end
                else if (col_out)
                begin
                    op.status = pbd_pkg::STATUS_CLIPPED;
                end
                else
                begin
                    op.status = pbd_pkg::STATUS_DRAWN;
                    op.fb_wr  = 1'b1;
                end
            end
            pbd_pkg::ACT_FB_READ:
            begin
                op.rd_ok = addr_in_range;
            end
            pbd_pkg::ACT_FB_WRITE:
            begin
                op.fb_wr = addr_in_range;
                op.store = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/pbd_pixel.sv @@
//------------------------------------------------------------------------------
// pbd_pixel
// Write-back stage datapath: luma, dither decision and byte merge.
//------------------------------------------------------------------------------
`default_nettype none

module pbd_pixel (
    input  wire pbd_pkg::pbd_op_t op,
    input  wire logic [15:0]      color_raw,
    input  wire logic [7:0]       cur_byte,
    output      logic [7:0]       new_byte,
    output      logic [7:0]       read_data
);

    logic [15:0] color;
    logic [6:0]  luma_sum;
    logic [5:0]  luma;
    logic        black;

    assign color    = op.pal_oob ? 16'h0000 : color_raw;
    assign luma_sum = 7'(color[15:11]) + 7'(color[10:5]) + 7'(color[4:0]);
    assign luma     = luma_sum[6:1];
    assign black    = luma < op.thresh;

    always_comb
    begin
        if (op.store)
        begin
            new_byte = op.wr_byte;
        end
        else if (black)
        begin
            new_byte = cur_byte & ~op.mask;
        end
        else
        begin
            new_byte = cur_byte | op.mask;
        end
    end

    assign read_data = op.rd_ok ? cur_byte : 8'h00;

endmodule

`default_nettype wire

@@ rtl/palette_bayer_dither_framebuffer.sv @@
//------------------------------------------------------------------------------
// palette_bayer_dither_framebuffer
// Palette lookup, 8x8 ordered dither and 1-bit framebuffer with byte access.
//------------------------------------------------------------------------------
// The block takes one command transaction per clock cycle while cmd_stall is
// low and returns exactly one response transaction for each, in order. A
// command passes from acceptance through the write-back stage to the output
// register: in the accepting cycle the palette RAM and the framebuffer RAM are
// read, and in the write-back stage the byte is merged, written back and the
// response is loaded into the output register. The framebuffer read-modify-write
// is forwarded from one command to the next, so pixels that share a byte still
// stream at one per cycle while no stall holds them. When a response is held
// by rsp_stall and the write-back stage also holds a command, cmd_stall is high
// in that same cycle until the output register drains. After reset the
// framebuffer RAM is swept to white one byte per cycle over all FB_BYTES
// bytes (4736 at the default size); cmd_stall stays high during that sweep,
// while configuration writes are taken as usual. Configuration should only
// be written while no command is in flight. Palette entries hold no value
// until written.
//------------------------------------------------------------------------------
`default_nettype none

module palette_bayer_dither_framebuffer #(
    parameter int FB_WIDTH     = 296,
    parameter int FB_HEIGHT    = 128,
    parameter int PALETTE_SIZE = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data,
    // Command channel
    input  wire logic        cmd_valid,
    output      logic        cmd_stall,
    input  wire logic [1:0]  action,
    input  wire logic [10:0] pix_x,
    input  wire logic [10:0] pix_y,
    input  wire logic [7:0]  color_index,
    input  wire logic [15:0] color_value,
    input  wire logic [12:0] fb_address,
    input  wire logic [7:0]  fb_byte,
    // Response channel
    output      logic        rsp_valid,
    input  wire logic        rsp_stall,
    output      logic [7:0]  read_data,
    output      logic [1:0]  status
);

    localparam int ROW_BYTES = (FB_WIDTH + 7) / 8;
    localparam int FB_BYTES  = ROW_BYTES * FB_HEIGHT;
    localparam int FB_AW     = $clog2(FB_BYTES);
    localparam int PAL_AW    = $clog2(PALETTE_SIZE);

    // Configuration registers.
    logic [11:0] offset_x_reg;
    logic [11:0] offset_y_reg;
    logic        transparent_enable_reg;
    logic [7:0]  transparent_index_reg;

    // Clearing sweep.
    logic             clear_active_reg;
    logic [FB_AW-1:0] clear_addr_reg;

    // Decode outputs for the command being offered.
    pbd_pkg::pbd_op_t dec_op;
    logic [FB_AW-1:0] dec_addr;
    logic             dec_pal_hit;

    // Write-back stage.
    logic             wb_valid_reg;
    pbd_pkg::pbd_op_t wb_op_reg;
    logic [FB_AW-1:0] wb_addr_reg;

    // Most recent framebuffer write by the write-back stage.
    logic             fwd_valid_reg;
    logic [FB_AW-1:0] fwd_addr_reg;
    logic [7:0]       fwd_data_reg;

    // Output register.
    logic       rsp_valid_reg;
    logic [7:0] read_data_reg;
    logic [1:0] status_reg;

    logic             cmd_accept;
    logic             wb_fire;
    logic             wb_write;
    logic [15:0]      color_raw;
    logic [7:0]       fb_rdata;
    logic [7:0]       cur_byte;
    logic [7:0]       new_byte;
    logic [7:0]       wb_read_data;
    logic             pal_we;
    logic             fb_we;
    logic [FB_AW-1:0] fb_waddr;
    logic [7:0]       fb_wdata;

    // The write-back stage empties whenever the output register is free or
    // being drained; a new command enters only when that slot opens.
    assign wb_fire    = wb_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign cmd_stall  = clear_active_reg || (wb_valid_reg && !wb_fire);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign wb_write   = wb_fire && wb_op_reg.fb_wr;

    //--------------------------------------------------------------------------
    // Configuration
    //--------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg           <= '0;
            offset_y_reg           <= '0;
            transparent_enable_reg <= 1'b0;
            transparent_index_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pbd_pkg::REG_OFFSET_X:           offset_x_reg <= cfg_data;
                pbd_pkg::REG_OFFSET_Y:           offset_y_reg <= cfg_data;
                pbd_pkg::REG_TRANSPARENT_ENABLE: transparent_enable_reg <= cfg_data[0];
                pbd_pkg::REG_TRANSPARENT_INDEX:  transparent_index_reg <= cfg_data[7:0];
            endcase
        end
    end

    //--------------------------------------------------------------------------
    // Clearing sweep: writes white to every framebuffer byte after reset.
    //--------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end
        else if (clear_active_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == FB_AW'(FB_BYTES - 1))
            begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    //--------------------------------------------------------------------------
    // Acceptance stage
    //--------------------------------------------------------------------------
    pbd_decode #(
        .FB_WIDTH     (FB_WIDTH),
        .FB_HEIGHT    (FB_HEIGHT),
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_decode (
        .action             (action),
        .pix_x              (pix_x),
        .pix_y              (pix_y),
        .color_index        (color_index),
        .fb_address         (fb_address),
        .fb_byte            (fb_byte),
        .offset_x           (offset_x_reg),
        .offset_y           (offset_y_reg),
        .transparent_enable (transparent_enable_reg),
        .transparent_index  (transparent_index_reg),
        .op                 (dec_op),
        .fb_addr            (dec_addr),
        .pal_hit            (dec_pal_hit)
    );

    // Palette writes complete at acceptance, so a later draw always sees them.
    assign pal_we = cmd_accept && (action == pbd_pkg::ACT_PALETTE_WRITE) && dec_pal_hit;

    pbd_ram #(
        .WIDTH (16),
        .DEPTH (PALETTE_SIZE)
    ) u_palette_ram (
        .clk   (clk),
        .we    (pal_we),
        .waddr (PAL_AW'(color_index)),
        .wdata (color_value),
        .re    (cmd_accept),
        .raddr (PAL_AW'(color_index)),
        .rdata (color_raw)
    );

    // Framebuffer write port is shared by the clearing sweep and write-back.
    assign fb_we    = clear_active_reg || wb_write;
    assign fb_waddr = clear_active_reg ? clear_addr_reg : wb_addr_reg;
    assign fb_wdata = clear_active_reg ? 8'hFF : new_byte;

    pbd_ram #(
        .WIDTH (8),
        .DEPTH (FB_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (fb_we),
        .waddr (fb_waddr),
        .wdata (fb_wdata),
        .re    (cmd_accept),
        .raddr (dec_addr),
        .rdata (fb_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
        end
        else if (cmd_accept)
        begin
            wb_valid_reg <= 1'b1;
        end
        else if (wb_fire)
        begin
            wb_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            wb_op_reg   <= dec_op;
            wb_addr_reg <= dec_addr;
        end
    end

    //--------------------------------------------------------------------------
    // Write-back stage
    //--------------------------------------------------------------------------
    // The RAM returned the byte as it stood before the write-back in the
    // accepting cycle. The last write is always the newest copy of its byte,
    // so a matching address takes the forwarded value.
    assign cur_byte = (fwd_valid_reg && (fwd_addr_reg == wb_addr_reg)) ?
                      fwd_data_reg : fb_rdata;

    pbd_pixel u_pixel (
        .op        (wb_op_reg),
        .color_raw (color_raw),
        .cur_byte  (cur_byte),
        .new_byte  (new_byte),
        .read_data (wb_read_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (wb_write)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb_write)
        begin
            fwd_addr_reg <= wb_addr_reg;
            fwd_data_reg <= new_byte;
        end
    end

    //--------------------------------------------------------------------------
    // Output register
    //--------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (wb_fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb_fire)
        begin
            read_data_reg <= wb_read_data;
            status_reg    <= wb_op_reg.status;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign read_data = read_data_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

@@ rtl/pbd_checker.sv @@
//------------------------------------------------------------------------------
// pbd_checker
// Port-level checks on the response channel, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

`include "palette_bayer_dither_framebuffer_assert.svh"

module pbd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cmd_valid,
    input wire logic       cmd_stall,
    input wire logic       rsp_valid,
    input wire logic       rsp_stall,
    input wire logic [7:0] read_data,
    input wire logic [1:0] status
);

    // A stalled response keeps its valid and its payload.
    `PBD_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(read_data) && $stable(status))

    // Every accepted command is followed by a valid response in the output register.
    `PBD_ASSERT_SAME(a_rsp_latency, clk, rst_n, $past(cmd_valid && !cmd_stall, 2), rsp_valid)

    // Only a framebuffer read returns data, and reads always report done.
    `PBD_ASSERT_SAME(a_data_status, clk, rst_n, rsp_valid && (read_data != 8'h00), status == pbd_pkg::STATUS_DONE)

endmodule

bind palette_bayer_dither_framebuffer pbd_checker u_pbd_checker (.*);

`default_nettype wire
